// File: rtl/dual_timer_tod_interrupt_adapter_defines.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef DUAL_TIMER_TOD_INTERRUPT_ADAPTER_DEFINES_SVH
`define DUAL_TIMER_TOD_INTERRUPT_ADAPTER_DEFINES_SVH
// Asserts that an implication holds at every clock edge outside reset.
`define DTIA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Asserts that the consequent holds in the cycle after the antecedent, outside reset.
`define DTIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/dtia_pkg.sv
// Package for the dual timer adapter: action and register codes, payload types and a load helper.
// No dependencies.
package dtia_pkg;
   typedef enum logic [1:0] {
      ACT_READ = 2'd0, ACT_WRITE = 2'd1, ACT_TICK = 2'd2, ACT_TOD = 2'd3
   } action_type;
   localparam logic [3:0] REG_PRA = 4'd0, REG_PRB = 4'd1, REG_DDRA = 4'd2, REG_DDRB = 4'd3,
      REG_TALO = 4'd4, REG_TAHI = 4'd5, REG_TBLO = 4'd6, REG_TBHI = 4'd7,
      REG_TODLO = 4'd8, REG_TODMID = 4'd9, REG_TODHI = 4'd10, REG_UNUSED = 4'd11,
      REG_SDR = 4'd12, REG_ICR = 4'd13, REG_CRA = 4'd14, REG_CRB = 4'd15;
   typedef struct packed {
      logic [1:0] action;
      logic [3:0] reg_index;
      logic [7:0] write_data;
   } req_type;
   typedef struct packed {
      logic [7:0] read_data;
      logic irq;
   } rsp_type;
   function automatic logic [15:0] nonzero(input logic [15:0] v);
      nonzero = (v == 16'd0) ? 16'd1 : v;
   endfunction
endpackage

// File: rtl/dtia_if.sv
// Valid/ready channel interface for the dual timer adapter.
// Depends on dtia_pkg.
interface dtia_req_if;
   logic valid;
   logic ready;
   dtia_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dtia_rsp_if;
   logic valid;
   logic ready;
   dtia_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/dual_timer_tod_interrupt_adapter.sv
// Channel   Direction  Payload
// req       in         action, reg_index, write_data
// rsp       out        read_data, irq
// Each transfer on req is processed in the cycle it is taken; one rsp
// transfer follows from the output register in the next cycle. A new req is
// taken every cycle while the output register is empty or being drained.
// Synchronous reset restores every register but the output payload register to its power-up value.
// Stalls on rsp hold the output register and stop req intake.
// Depends on dtia_pkg and dtia_if.
module dual_timer_tod_interrupt_adapter (
   input logic clock,
   input logic reset,
   dtia_req_if.sink req_ch,
   dtia_rsp_if.source rsp_ch
);
   logic [15:0] ta_ff, ta_in, tb_ff, tb_in, ra_ff, ra_in, rb_ff, rb_in;
   logic [7:0] cra_ff, cra_in, crb_ff, crb_in;
   logic [23:0] tod_ff, tod_in, alm_ff, alm_in, rcp_ff, rcp_in, wcp_ff, wcp_in;
   logic rh_ff, rh_in, wh_ff, wh_in;
   logic [7:0] icr_ff, icr_in;
   logic [4:0] ien_ff, ien_in;
   logic [7:0] pa_ff, pa_in, pb_ff, pb_in, db_ff, db_in, sd_ff, sd_in;
   logic vld_ff, vld_in;
   dtia_pkg::rsp_type out_ff, out_in;
   logic take;
   logic [7:0] d, rd;
   logic [3:0] r;
   logic alarm_chk, b_free;
   logic [23:0] todm1;

   assign req_ch.ready = !vld_ff || rsp_ch.ready;
   assign take = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = vld_ff;
   assign rsp_ch.payload = out_ff;
   assign d = req_ch.payload.write_data;
   assign r = req_ch.payload.reg_index;

   always_comb begin
      ta_in = ta_ff; tb_in = tb_ff; ra_in = ra_ff; rb_in = rb_ff;
      cra_in = cra_ff; crb_in = crb_ff; tod_in = tod_ff; alm_in = alm_ff;
      rcp_in = rcp_ff; wcp_in = wcp_ff; rh_in = rh_ff; wh_in = wh_ff;
      icr_in = icr_ff; ien_in = ien_ff; pa_in = pa_ff; pb_in = pb_ff;
      db_in = db_ff; sd_in = sd_ff;
      rd = 8'd0; alarm_chk = 1'b0; todm1 = 24'd0;
      b_free = (crb_ff & 8'h41) == 8'h01;
      vld_in = vld_ff && !rsp_ch.ready;
      if (take) begin
         vld_in = 1'b1;
         case (dtia_pkg::action_type'(req_ch.payload.action))
            dtia_pkg::ACT_READ: begin
               case (r)
                  dtia_pkg::REG_PRA: rd = pa_ff;
                  dtia_pkg::REG_PRB: rd = pb_ff;
                  dtia_pkg::REG_DDRA: rd = 8'd3;
                  dtia_pkg::REG_DDRB: rd = db_ff;
                  dtia_pkg::REG_TALO: rd = ta_ff[7:0];
                  dtia_pkg::REG_TAHI: rd = ta_ff[15:8];
                  dtia_pkg::REG_TBLO: rd = tb_ff[7:0];
                  dtia_pkg::REG_TBHI: rd = tb_ff[15:8];
                  dtia_pkg::REG_TODLO: begin
                     rd = rh_ff ? rcp_ff[7:0] : tod_ff[7:0];
                     rh_in = 1'b0;
                  end
                  dtia_pkg::REG_TODMID: rd = rh_ff ? rcp_ff[15:8] : tod_ff[15:8];
                  dtia_pkg::REG_TODHI: begin
                     rh_in = 1'b1; rcp_in = tod_ff; rd = tod_ff[23:16];
                  end
                  dtia_pkg::REG_SDR: rd = sd_ff;
                  dtia_pkg::REG_ICR: begin
                     rd = icr_ff; icr_in = 8'd0;
                  end
                  dtia_pkg::REG_CRA: rd = cra_ff;
                  dtia_pkg::REG_CRB: rd = crb_ff;
                  default: rd = 8'hff;
               endcase
            end
            dtia_pkg::ACT_WRITE: begin
               case (r)
                  dtia_pkg::REG_PRA: pa_in = d;
                  dtia_pkg::REG_PRB: pb_in = d;
                  dtia_pkg::REG_DDRB: db_in = d;
                  dtia_pkg::REG_TALO: ra_in = {ra_ff[15:8], d};
                  dtia_pkg::REG_TAHI: begin
                     ra_in = {d, ra_ff[7:0]};
                     if (!cra_ff[0] || cra_ff[3]) ta_in = dtia_pkg::nonzero(ra_in);
                     if (cra_ff[3]) cra_in[0] = 1'b1;
                  end
                  dtia_pkg::REG_TBLO: rb_in = {rb_ff[15:8], d};
                  dtia_pkg::REG_TBHI: begin
                     rb_in = {d, rb_ff[7:0]};
                     if (!crb_ff[0] || crb_ff[3]) tb_in = dtia_pkg::nonzero(rb_in);
                     if (crb_ff[3]) crb_in[0] = 1'b1;
                  end
                  dtia_pkg::REG_TODLO: begin
                     if (crb_ff[7]) alm_in = {alm_ff[23:8], d};
                     else begin
                        wh_in = 1'b0; wcp_in = {wcp_ff[23:8], d}; tod_in = wcp_in;
                     end
                     alarm_chk = 1'b1;
                  end
                  dtia_pkg::REG_TODMID: begin
                     if (crb_ff[7]) begin
                        alm_in = {alm_ff[23:16], d, alm_ff[7:0]}; alarm_chk = 1'b1;
                     end else begin
                        wh_in = 1'b1; wcp_in = {wcp_ff[23:16], d, wcp_ff[7:0]};
                     end
                  end
                  dtia_pkg::REG_TODHI: begin
                     if (crb_ff[7]) begin
                        alm_in = {d, alm_ff[15:0]}; alarm_chk = 1'b1;
                     end else begin
                        wh_in = 1'b1; wcp_in = {d, wcp_ff[15:0]};
                     end
                  end
                  dtia_pkg::REG_SDR: sd_in = d;
                  dtia_pkg::REG_ICR: begin
                     if (d[7]) ien_in = ien_ff | d[4:0];
                     else ien_in = ien_ff & ~d[4:0];
                  end
                  dtia_pkg::REG_CRA: begin
                     if (d[4]) ta_in = dtia_pkg::nonzero(ra_ff);
                     cra_in = d & 8'hef;
                  end
                  dtia_pkg::REG_CRB: begin
                     if (d[4]) tb_in = dtia_pkg::nonzero(rb_ff);
                     crb_in = d & 8'hef;
                  end
                  default: ;
               endcase
            end
            dtia_pkg::ACT_TICK: begin
               if (cra_ff[0]) begin
                  ta_in = ta_ff - 16'd1;
                  if (ta_in == 16'd0) begin
                     ta_in = dtia_pkg::nonzero(ra_ff);
                     if ((crb_ff & 8'h41) == 8'h41) begin
                        tb_in = tb_ff - 16'd1;
                        if (tb_in == 16'd0) begin
                           tb_in = dtia_pkg::nonzero(rb_ff);
                           if (crb_ff[3]) crb_in[0] = 1'b0;
                           icr_in[1] = 1'b1;
                        end
                     end
                     if (cra_ff[3]) cra_in[0] = 1'b0;
                     icr_in[0] = 1'b1;
                  end
               end
               if (b_free) begin
                  tb_in = tb_ff - 16'd1;
                  if (tb_in == 16'd0) begin
                     tb_in = dtia_pkg::nonzero(rb_ff);
                     if (crb_ff[3]) crb_in[0] = 1'b0;
                     icr_in[1] = 1'b1;
                  end
               end
            end
            default: begin
               if (!wh_ff) begin
                  tod_in = tod_ff + 24'd1; alarm_chk = 1'b1;
               end
            end
         endcase
         if (alarm_chk && !wh_in) begin
            todm1 = tod_in - 24'd1;
            if (tod_in == alm_in ||
                (tod_in[11:0] == 12'd0 && {todm1[23:12], 12'd0} == alm_in))
               icr_in[2] = 1'b1;
         end
         if ((icr_in[4:0] & ien_in) != 5'd0) icr_in[7] = 1'b1;
      end
      out_in = out_ff;
      if (take) begin
         out_in.read_data = rd;
         out_in.irq = icr_in[7];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ta_ff <= 16'hffff; tb_ff <= 16'hffff; ra_ff <= 16'hffff; rb_ff <= 16'hffff;
         cra_ff <= 8'd0; crb_ff <= 8'd0; tod_ff <= 24'd0; alm_ff <= 24'd0;
         rcp_ff <= 24'd0; wcp_ff <= 24'd0; rh_ff <= 1'b0; wh_ff <= 1'b1;
         icr_ff <= 8'd0; ien_ff <= 5'd0; pa_ff <= 8'hff; pb_ff <= 8'd0;
         db_ff <= 8'd0; sd_ff <= 8'd0; vld_ff <= 1'b0;
      end else begin
         ta_ff <= ta_in; tb_ff <= tb_in; ra_ff <= ra_in; rb_ff <= rb_in;
         cra_ff <= cra_in; crb_ff <= crb_in; tod_ff <= tod_in; alm_ff <= alm_in;
         rcp_ff <= rcp_in; wcp_ff <= wcp_in; rh_ff <= rh_in; wh_ff <= wh_in;
         icr_ff <= icr_in; ien_ff <= ien_in; pa_ff <= pa_in; pb_ff <= pb_in;
         db_ff <= db_in; sd_ff <= sd_in; vld_ff <= vld_in;
      end
      out_ff <= out_in;
   end
endmodule

// File: rtl/dtia_checker.sv
// Port-level checker for the dual timer adapter and its bind statement.
// Depends on dtia_pkg, dtia_if and the defines header.
`include "dual_timer_tod_interrupt_adapter_defines.svh"
module dtia_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input dtia_pkg::rsp_type rsp_payload
);
   `DTIA_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid)
   `DTIA_ASSERT_IMPL(a_ready_empty, clock, reset, !rsp_valid, req_ready)
   `DTIA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))
endmodule

bind dual_timer_tod_interrupt_adapter dtia_checker u_dtia_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_payload(rsp_ch.payload)
);

// File: bench/dual_timer_tod_interrupt_adapter_tb_pkg.sv
// Scoreboard class for the dual timer adapter bench: predicts each result.
// Depends on dtia_pkg.
`timescale 1ns / 1ps
package dual_timer_tod_interrupt_adapter_tb_pkg;

   class adapter_scoreboard;
      logic [15:0] ta_count, tb_count, ta_latch, tb_latch;
      logic [7:0] cra, crb, icr_req, pra, prb, ddrb, sdr;
      logic [4:0] icr_mask;
      logic [23:0] tod, alarm, tod_snap, tod_stage;
      bit snap_held, stage_held;
      dtia_pkg::rsp_type pending[$];
      int errors;

      function new();
         ta_count = 16'hffff; tb_count = 16'hffff;
         ta_latch = 16'hffff; tb_latch = 16'hffff;
         cra = '0; crb = '0; tod = '0; alarm = '0; tod_snap = '0; tod_stage = '0;
         snap_held = 1'b0; stage_held = 1'b1; icr_req = '0; icr_mask = '0;
         pra = 8'hff; prb = '0; ddrb = '0; sdr = '0; errors = 0;
      endfunction

      function logic [15:0] load_value(logic [15:0] v);
         return (v == 16'd0) ? 16'd1 : v;
      endfunction

      function void refresh_line();
         if ((icr_req[4:0] & icr_mask) != 5'd0) icr_req[7] = 1'b1;
      endfunction

      function void flag(logic [4:0] bits);
         icr_req = icr_req | {3'b000, bits};
         refresh_line();
      endfunction

      function void alarm_match();
         logic [23:0] prev;
         prev = tod - 24'd1;
         if (stage_held) return;
         if (tod == alarm || (tod[11:0] == 12'd0 && {prev[23:12], 12'h000} == alarm))
            flag(5'h04);
      endfunction

      function void b_underflow();
         tb_count = load_value(tb_latch);
         if (crb[3]) crb[0] = 1'b0;
         flag(5'h02);
      endfunction

      function void a_underflow();
         ta_count = load_value(ta_latch);
         if ((crb & 8'h41) == 8'h41) begin
            tb_count = tb_count - 16'd1;
            if (tb_count == 16'd0) b_underflow();
         end
         if (cra[3]) cra[0] = 1'b0;
         flag(5'h01);
      endfunction

      function void count_tick();
         bit b_free;
         b_free = (crb & 8'h41) == 8'h01;
         if (cra[0]) begin
            ta_count = ta_count - 16'd1;
            if (ta_count == 16'd0) a_underflow();
         end
         if (b_free && (crb & 8'h41) == 8'h01) begin
            tb_count = tb_count - 16'd1;
            if (tb_count == 16'd0) b_underflow();
         end
      endfunction

      function logic [7:0] reg_read(logic [3:0] r);
         logic [7:0] v;
         case (r)
            dtia_pkg::REG_PRA: v = pra;
            dtia_pkg::REG_PRB: v = prb;
            dtia_pkg::REG_DDRA: v = 8'd3;
            dtia_pkg::REG_DDRB: v = ddrb;
            dtia_pkg::REG_TALO: v = ta_count[7:0];
            dtia_pkg::REG_TAHI: v = ta_count[15:8];
            dtia_pkg::REG_TBLO: v = tb_count[7:0];
            dtia_pkg::REG_TBHI: v = tb_count[15:8];
            dtia_pkg::REG_TODLO: begin
               v = snap_held ? tod_snap[7:0] : tod[7:0];
               snap_held = 1'b0;
            end
            dtia_pkg::REG_TODMID: v = snap_held ? tod_snap[15:8] : tod[15:8];
            dtia_pkg::REG_TODHI: begin
               snap_held = 1'b1; tod_snap = tod; v = tod[23:16];
            end
            dtia_pkg::REG_SDR: v = sdr;
            dtia_pkg::REG_ICR: begin
               v = icr_req; icr_req = '0;
            end
            dtia_pkg::REG_CRA: v = cra;
            dtia_pkg::REG_CRB: v = crb;
            default: v = 8'hff;
         endcase
         return v;
      endfunction

      function void reg_write(logic [3:0] r, logic [7:0] d);
         case (r)
            dtia_pkg::REG_PRA: pra = d;
            dtia_pkg::REG_PRB: prb = d;
            dtia_pkg::REG_DDRB: ddrb = d;
            dtia_pkg::REG_TALO: ta_latch[7:0] = d;
            dtia_pkg::REG_TAHI: begin
               ta_latch[15:8] = d;
               if (!cra[0] || cra[3]) ta_count = load_value(ta_latch);
               if (cra[3]) cra[0] = 1'b1;
            end
            dtia_pkg::REG_TBLO: tb_latch[7:0] = d;
            dtia_pkg::REG_TBHI: begin
               tb_latch[15:8] = d;
               if (!crb[0] || crb[3]) tb_count = load_value(tb_latch);
               if (crb[3]) crb[0] = 1'b1;
            end
            dtia_pkg::REG_TODLO: begin
               if (crb[7]) alarm[7:0] = d;
               else begin
                  stage_held = 1'b0; tod_stage[7:0] = d; tod = tod_stage;
               end
               alarm_match();
            end
            dtia_pkg::REG_TODMID: begin
               if (crb[7]) begin
                  alarm[15:8] = d; alarm_match();
               end else begin
                  stage_held = 1'b1; tod_stage[15:8] = d;
               end
            end
            dtia_pkg::REG_TODHI: begin
               if (crb[7]) begin
                  alarm[23:16] = d; alarm_match();
               end else begin
                  stage_held = 1'b1; tod_stage[23:16] = d;
               end
            end
            dtia_pkg::REG_SDR: sdr = d;
            dtia_pkg::REG_ICR: begin
               if (d[7]) icr_mask = icr_mask | d[4:0];
               else icr_mask = icr_mask & ~d[4:0];
               refresh_line();
            end
            dtia_pkg::REG_CRA: begin
               if (d[4]) ta_count = load_value(ta_latch);
               cra = d & 8'hef;
            end
            dtia_pkg::REG_CRB: begin
               if (d[4]) tb_count = load_value(tb_latch);
               crb = d & 8'hef;
            end
            default: ;
         endcase
      endfunction

      function void note_request(dtia_pkg::req_type q);
         dtia_pkg::rsp_type e;
         e.read_data = 8'd0;
         case (dtia_pkg::action_type'(q.action))
            dtia_pkg::ACT_READ: e.read_data = reg_read(q.reg_index);
            dtia_pkg::ACT_WRITE: reg_write(q.reg_index, q.write_data);
            dtia_pkg::ACT_TICK: count_tick();
            default: if (!stage_held) begin
               tod = tod + 24'd1; alarm_match();
            end
         endcase
         e.irq = icr_req[7];
         pending.push_back(e);
      endfunction

      function void check_response(dtia_pkg::rsp_type got);
         dtia_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("response with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.read_data !== e.read_data) begin
            $error("read_data expected %0h actual %0h", e.read_data, got.read_data);
            errors++;
         end
         if (got.irq !== e.irq) begin
            $error("irq expected %0b actual %0b", e.irq, got.irq);
            errors++;
         end
      endfunction
   endclass
endpackage

// File: bench/dual_timer_tod_interrupt_adapter_test.sv
// Top of the dual timer adapter bench: directed and random register traffic
// with random stalls, checked by the scoreboard. Depends on dtia_pkg, dtia_if
// and dual_timer_tod_interrupt_adapter_tb_pkg.
`timescale 1ns / 1ps
module dual_timer_tod_interrupt_adapter_test;

   logic clock = 0;
   logic reset = 1;
   dtia_req_if req_ch();
   dtia_rsp_if rsp_ch();
   dual_timer_tod_interrupt_adapter_tb_pkg::adapter_scoreboard board;
   bit sending_done = 0;
   int hold_off = 0;

   dual_timer_tod_interrupt_adapter dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
      board = new();
   end

   task automatic send(dtia_pkg::action_type a, logic [3:0] r, logic [7:0] d);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 1) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.payload <= '{action: a, reg_index: r, write_data: d};
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(req_ch.payload);
      @(negedge clock);
   endtask

   task automatic send_random();
      int k;
      logic [3:0] r;
      k = $urandom_range(0, 99);
      r = 4'($urandom_range(0, 15));
      if (k < 40) send(dtia_pkg::ACT_TICK, r, 8'($urandom));
      else if (k < 55) send(dtia_pkg::ACT_TOD, r, 8'($urandom));
      else if (k < 75) send(dtia_pkg::ACT_READ, r, 8'($urandom));
      else if (k < 85)
         send(dtia_pkg::ACT_WRITE,
              4'($urandom_range(dtia_pkg::REG_TALO, dtia_pkg::REG_TBHI)),
              8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom));
      else send(dtia_pkg::ACT_WRITE, r, 8'($urandom));
   endtask

   initial begin
      int i;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send(dtia_pkg::ACT_READ, dtia_pkg::REG_PRA, 8'd0);
      send(dtia_pkg::ACT_READ, dtia_pkg::REG_DDRA, 8'd0);
      send(dtia_pkg::ACT_READ, dtia_pkg::REG_UNUSED, 8'd0);
      send(dtia_pkg::ACT_TOD, 4'd0, 8'd0);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_ICR, 8'h9f);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TALO, 8'h02);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TAHI, 8'h00);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_CRA, 8'h19);
      send(dtia_pkg::ACT_TICK, 4'd0, 8'd0);
      send(dtia_pkg::ACT_TICK, 4'd0, 8'd0);
      send(dtia_pkg::ACT_READ, dtia_pkg::REG_ICR, 8'd0);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TBLO, 8'h00);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TBHI, 8'h00);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_CRB, 8'h51);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_CRA, 8'h11);
      send(dtia_pkg::ACT_TICK, 4'd0, 8'd0);
      send(dtia_pkg::ACT_TICK, 4'd0, 8'd0);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TODHI, 8'hff);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TODMID, 8'hff);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TODLO, 8'hff);
      send(dtia_pkg::ACT_TOD, 4'd0, 8'd0);
      send(dtia_pkg::ACT_READ, dtia_pkg::REG_TODHI, 8'd0);
      send(dtia_pkg::ACT_READ, dtia_pkg::REG_TODMID, 8'd0);
      send(dtia_pkg::ACT_READ, dtia_pkg::REG_TODLO, 8'd0);
      send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_ICR, 8'h1f);
      for (i = 0; i < 540; i++) begin
         if (i == 300) hold_off = 60;
         if ($urandom_range(0, 49) == 0) begin
            send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_CRB, 8'h80);
            send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TODHI, 8'h00);
            send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TODMID, 8'h10);
            send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TODLO, 8'h00);
            send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_CRB, 8'h00);
            send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TODHI, 8'h00);
            send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TODMID, 8'h0f);
            send(dtia_pkg::ACT_WRITE, dtia_pkg::REG_TODLO, 8'hff);
            send(dtia_pkg::ACT_TOD, 4'd0, 8'd0);
         end
         send_random();
      end
      req_ch.valid <= 0;
      sending_done = 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.payload);
   end

   initial begin
      int stall;
      @(negedge clock);
      forever begin
         if (hold_off > 0) begin
            rsp_ch.ready <= 0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end
         stall = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ch.ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1;
         @(negedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready) && hold_off == 0) @(negedge clock);
      end
   end

   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0) $display("[dual_timer_tod_interrupt_adapter] OK");
      else $display("[dual_timer_tod_interrupt_adapter] ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("[dual_timer_tod_interrupt_adapter] ERROR");
      $finish;
   end
endmodule

// File: dual_timer_tod_interrupt_adapter.f
+incdir+rtl
rtl/dtia_pkg.sv
rtl/dtia_if.sv
rtl/dual_timer_tod_interrupt_adapter.sv
rtl/dtia_checker.sv
bench/dual_timer_tod_interrupt_adapter_tb_pkg.sv
bench/dual_timer_tod_interrupt_adapter_test.sv
